>>> rtl/neural_activation_unit_top_defines.svh
// assertion helpers for the activation unit checker
`ifndef NEURAL_ACTIVATION_UNIT_TOP_DEFINES_SVH
`define NEURAL_ACTIVATION_UNIT_TOP_DEFINES_SVH

// same-cycle implication, gated by reset
`define NAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define NAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nau_pkg.sv
package nau_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OpWidth     = 3;
  localparam int unsigned CoefWidth   = 16;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned ExpArgWidth = 38;
  localparam int unsigned KWidth      = 7;
  localparam int unsigned ExpWidth    = 33;
  localparam int unsigned ProdWidth   = CoefWidth + ExpWidth;
  localparam int unsigned NumTerms    = 13;

  localparam logic [ExpArgWidth-1:0] Ln2Q32 = 38'h00_B172_17F8;
  localparam logic [ExpWidth-1:0]    OneQ32 = 33'h1_0000_0000;

  localparam logic [CfgIdxWidth-1:0] RegEluAlpha   = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegSeluLambda = 4'd1;

  localparam logic [CoefWidth-1:0] EluAlphaRst   = 16'd4096;
  localparam logic [CoefWidth-1:0] SeluLambdaRst = 16'd4304;

  typedef enum logic [OpWidth-1:0] {
    OpIdent   = 3'd0,
    OpSigmoid = 3'd1,
    OpTanh    = 3'd2,
    OpElu     = 3'd3,
    OpSelu    = 3'd4,
    OpRelu    = 3'd5
  } op_e;

  typedef struct packed {
    logic [OpWidth-1:0]          operation;
    logic signed [DataWidth-1:0] x_value;
  } nau_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] y_value;
    logic                        bad_operation;
    logic                        saturated;
  } nau_out_t;

  typedef struct packed {
    op_e                  op;
    logic                 bad;
    logic                 neg;
    logic [DataWidth-1:0] mag;
  } nau_ctx_t;

  typedef struct packed {
    nau_ctx_t             ctx;
    logic [ProdWidth-1:0] prod;
  } nau_mid_t;

endpackage

>>> rtl/neural_activation_unit_top.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i   (operation, x_value)
// out       output     out_valid_o / out_ready_i out_data_o  (y_value, flags)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction per cycle in steady state while the output is not stalled;
// the pipe holds 3 range-reduction stages, 26 taylor stages and FracBits + 1
// stages of the restoring divider.
// reset clears all valid bits and loads the default alpha and lambda.
// a stall at the output freezes the pipe only once the stage feeding the
// output register holds a transaction; bubbles still move up behind it.
module neural_activation_unit_top
  import nau_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  nau_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output nau_out_t               out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CoefWidth-1:0]   cfg_data_i
);

  logic [CoefWidth-1:0] alpha_q;
  logic [CoefWidth-1:0] lambda_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= EluAlphaRst;
      lambda_q <= SeluLambdaRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEluAlpha:   alpha_q  <= cfg_data_i;
        RegSeluLambda: lambda_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic                   en;
  logic                   fr_valid;
  nau_ctx_t               fr_ctx;
  logic [ExpArgWidth-1:0] fr_arg;
  logic                   fr_zero;
  logic                   ex_valid;
  nau_ctx_t               ex_ctx;
  logic [ExpWidth-1:0]    ex_e;
  logic                   dv_valid;
  nau_mid_t               dv_mid;
  logic [FracBits:0]      dv_quo;

  nau_front #(
    .FracBits (FracBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .valid_o    (fr_valid),
    .ctx_o      (fr_ctx),
    .arg_o      (fr_arg),
    .zero_o     (fr_zero)
  );

  nau_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .ctx_i   (fr_ctx),
    .arg_i   (fr_arg),
    .zero_i  (fr_zero),
    .valid_o (ex_valid),
    .ctx_o   (ex_ctx),
    .e_o     (ex_e)
  );

  nau_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ex_valid),
    .ctx_i   (ex_ctx),
    .e_i     (ex_e),
    .alpha_i (alpha_q),
    .valid_o (dv_valid),
    .mid_o   (dv_mid),
    .quo_o   (dv_quo)
  );

  nau_post #(
    .FracBits (FracBits)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dv_valid),
    .mid_i       (dv_mid),
    .quo_i       (dv_quo),
    .lambda_i    (lambda_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .en_o        (en)
  );

  assign in_ready_o = en;

endmodule

>>> rtl/nau_front.sv
module nau_front
  import nau_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   in_valid_i,
  input  nau_in_t                in_data_i,
  output logic                   valid_o,
  output nau_ctx_t               ctx_o,
  output logic [ExpArgWidth-1:0] arg_o,
  output logic                   zero_o
);

  localparam logic [DataWidth-1:0] ExpCap  = DataWidth'(64) << FracBits;
  localparam logic [DataWidth-1:0] TanhCap = DataWidth'(32) << FracBits;

  logic                   neg;
  logic [DataWidth-1:0]   xu;
  logic [DataWidth-1:0]   mag;
  logic                   bad;
  op_e                    op;
  logic                   zero_d;
  logic [ExpArgWidth-1:0] arg_d;

  logic                   valid_q;
  nau_ctx_t               ctx_q;
  logic [ExpArgWidth-1:0] arg_q;
  logic                   zero_q;

  assign xu  = in_data_i.x_value;
  assign neg = xu[DataWidth-1];
  assign mag = neg ? (DataWidth'(0) - xu) : xu;
  assign bad = in_data_i.operation[2] & in_data_i.operation[1];
  assign op  = bad ? OpIdent : op_e'(in_data_i.operation);

  // tanh works on e^-2|x|, so its argument is doubled
  always_comb begin
    if (op == OpTanh) begin
      zero_d = mag >= TanhCap;
      arg_d  = ExpArgWidth'(mag) << (33 - FracBits);
    end else begin
      zero_d = mag >= ExpCap;
      arg_d  = ExpArgWidth'(mag) << (32 - FracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q.op  <= op;
      ctx_q.bad <= bad;
      ctx_q.neg <= neg;
      ctx_q.mag <= mag;
      arg_q     <= arg_d;
      zero_q    <= zero_d;
    end
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign arg_o   = arg_q;
  assign zero_o  = zero_q;

endmodule

>>> rtl/nau_exp.sv
module nau_exp
  import nau_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  nau_ctx_t               ctx_i,
  input  logic [ExpArgWidth-1:0] arg_i,
  input  logic                   zero_i,
  output logic                   valid_o,
  output nau_ctx_t               ctx_o,
  output logic [ExpWidth-1:0]    e_o
);

  localparam int unsigned RWidth   = 32;
  localparam int unsigned SumWidth = ExpWidth + 1;
  localparam int unsigned HiShift  = 24;
  localparam int unsigned HiWidth  = ExpArgWidth - HiShift;
  localparam int unsigned RecShift = 16;
  localparam int unsigned RecWidth = 9;
  localparam int unsigned KpWidth  = HiWidth + RecWidth;
  // floor(2^40 / ln2q32), never overestimates the quotient
  localparam logic [RecWidth-1:0] LnRecip =
    RecWidth'((64'd1 << (HiShift + RecShift)) / 64'(Ln2Q32));

  // range reduction: reciprocal estimate of arg / ln2, low by at most one,
  // then remainder and a single correction step
  logic                   ra_v_q;
  nau_ctx_t               ra_ctx_q;
  logic                   ra_zero_q;
  logic [ExpArgWidth-1:0] ra_arg_q;
  logic [KWidth-1:0]      ra_k_q;

  logic                   rb_v_q;
  nau_ctx_t               rb_ctx_q;
  logic                   rb_zero_q;
  logic [ExpArgWidth-1:0] rb_rem_q;
  logic [KWidth-1:0]      rb_k_q;

  logic                   rc_v_q;
  nau_ctx_t               rc_ctx_q;
  logic                   rc_zero_q;
  logic [ExpArgWidth-1:0] rc_rem_q;
  logic [KWidth-1:0]      rc_k_q;

  logic [KpWidth-1:0]     k_prod;
  logic [KWidth-1:0]      k_est;
  logic [ExpArgWidth-1:0] k_ln2;
  logic                   rem_ge;

  assign k_prod = KpWidth'(arg_i[ExpArgWidth-1:HiShift]) * KpWidth'(LnRecip);
  assign k_est  = k_prod[RecShift +: KWidth];
  assign k_ln2  = ExpArgWidth'(ra_k_q) * Ln2Q32;
  assign rem_ge = rb_rem_q >= Ln2Q32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_v_q <= 1'b0;
      rb_v_q <= 1'b0;
      rc_v_q <= 1'b0;
    end else if (en_i) begin
      ra_v_q <= valid_i;
      rb_v_q <= ra_v_q;
      rc_v_q <= rb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_ctx_q  <= ctx_i;
      ra_zero_q <= zero_i;
      ra_arg_q  <= arg_i;
      ra_k_q    <= k_est;

      rb_ctx_q  <= ra_ctx_q;
      rb_zero_q <= ra_zero_q;
      rb_rem_q  <= ra_arg_q - k_ln2;
      rb_k_q    <= ra_k_q;

      rc_ctx_q  <= rb_ctx_q;
      rc_zero_q <= rb_zero_q;
      rc_rem_q  <= rem_ge ? (rb_rem_q - Ln2Q32) : rb_rem_q;
      rc_k_q    <= rb_k_q + KWidth'(rem_ge);
    end
  end

  // taylor series of e^-r, two stages per term: multiply, then divide by n
  logic                ta_v_q    [NumTerms];
  nau_ctx_t            ta_ctx_q  [NumTerms];
  logic                ta_zero_q [NumTerms];
  logic [KWidth-1:0]   ta_k_q    [NumTerms];
  logic [RWidth-1:0]   ta_r_q    [NumTerms];
  logic [SumWidth-1:0] ta_sum_q  [NumTerms];
  logic [RWidth-1:0]   ta_p_q    [NumTerms];

  logic                tb_v_q    [NumTerms];
  nau_ctx_t            tb_ctx_q  [NumTerms];
  logic                tb_zero_q [NumTerms];
  logic [KWidth-1:0]   tb_k_q    [NumTerms];
  logic [RWidth-1:0]   tb_r_q    [NumTerms];
  logic [SumWidth-1:0] tb_sum_q  [NumTerms];
  logic [ExpWidth-1:0] tb_term_q [NumTerms];

  for (genvar t = 0; t < NumTerms; t++) begin : g_term
    localparam int unsigned N = t + 1;
    localparam int unsigned L = $clog2(N);
    localparam bit Odd = (N % 2) == 1;
    // exact floor(v / n) for any 32-bit v
    localparam logic [32:0] Recip =
      33'(((65'd1 << (32 + L)) + 65'(N) - 65'd1) / 65'(N));

    logic                src_v;
    nau_ctx_t            src_ctx;
    logic                src_zero;
    logic [KWidth-1:0]   src_k;
    logic [RWidth-1:0]   src_r;
    logic [SumWidth-1:0] src_sum;
    logic [ExpWidth-1:0] src_term;
    logic [64:0]         prod;
    logic [64:0]         qprod;
    logic [RWidth-1:0]   q;

    if (t == 0) begin : g_head
      assign src_v    = rc_v_q;
      assign src_ctx  = rc_ctx_q;
      assign src_zero = rc_zero_q;
      assign src_k    = rc_k_q;
      assign src_r    = rc_rem_q[RWidth-1:0];
      assign src_sum  = SumWidth'(OneQ32);
      assign src_term = OneQ32;
    end else begin : g_body
      assign src_v    = tb_v_q[t-1];
      assign src_ctx  = tb_ctx_q[t-1];
      assign src_zero = tb_zero_q[t-1];
      assign src_k    = tb_k_q[t-1];
      assign src_r    = tb_r_q[t-1];
      assign src_sum  = tb_sum_q[t-1];
      assign src_term = tb_term_q[t-1];
    end

    assign prod  = 65'(src_term) * 65'(src_r);
    assign qprod = 65'(ta_p_q[t]) * 65'(Recip);
    assign q     = qprod[32+L +: RWidth];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ta_v_q[t] <= 1'b0;
        tb_v_q[t] <= 1'b0;
      end else if (en_i) begin
        ta_v_q[t] <= src_v;
        tb_v_q[t] <= ta_v_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ta_ctx_q[t]  <= src_ctx;
        ta_zero_q[t] <= src_zero;
        ta_k_q[t]    <= src_k;
        ta_r_q[t]    <= src_r;
        ta_sum_q[t]  <= src_sum;
        ta_p_q[t]    <= prod[63:32];

        tb_ctx_q[t]  <= ta_ctx_q[t];
        tb_zero_q[t] <= ta_zero_q[t];
        tb_k_q[t]    <= ta_k_q[t];
        tb_r_q[t]    <= ta_r_q[t];
        tb_sum_q[t]  <= Odd ? (ta_sum_q[t] - SumWidth'(q)) : (ta_sum_q[t] + SumWidth'(q));
        tb_term_q[t] <= ExpWidth'(q);
      end
    end
  end

  // cap at 1.0, then scale by 2^-k; an argument past the cap gives zero
  logic [SumWidth-1:0] fin_sum;
  logic [ExpWidth-1:0] capped;
  logic [ExpWidth-1:0] e_d;
  logic                valid_q;
  nau_ctx_t            ctx_q;
  logic [ExpWidth-1:0] e_q;

  assign fin_sum = tb_sum_q[NumTerms-1];
  assign capped  = (fin_sum > SumWidth'(OneQ32)) ? OneQ32 : fin_sum[ExpWidth-1:0];
  assign e_d     = tb_zero_q[NumTerms-1] ? '0 : (capped >> tb_k_q[NumTerms-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tb_v_q[NumTerms-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= tb_ctx_q[NumTerms-1];
      e_q   <= e_d;
    end
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign e_o     = e_q;

endmodule

>>> rtl/nau_div.sv
module nau_div
  import nau_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  nau_ctx_t              ctx_i,
  input  logic [ExpWidth-1:0]   e_i,
  input  logic [CoefWidth-1:0]  alpha_i,
  output logic                  valid_o,
  output nau_mid_t              mid_o,
  output logic [FracBits:0]     quo_o
);

  localparam int unsigned QWidth   = FracBits + 1;
  localparam int unsigned DenWidth = ExpWidth + 1;
  localparam int unsigned RemWidth = DenWidth + FracBits;

  logic [ExpWidth-1:0] one_minus;
  logic [DenWidth-1:0] one_plus;
  logic [ExpWidth-1:0] num;
  logic [RemWidth-1:0] dividend;
  nau_mid_t            mid_d;

  assign one_minus = OneQ32 - e_i;
  assign one_plus  = DenWidth'(OneQ32) + DenWidth'(e_i);

  always_comb begin
    if (ctx_i.op == OpSigmoid) begin
      num = ctx_i.neg ? e_i : OneQ32;
    end else begin
      num = one_minus;
    end
  end

  // rounded ratio: (num * 2^frac + den / 2) / den
  assign dividend = (RemWidth'(num) << FracBits) + RemWidth'(one_plus >> 1);
  assign mid_d.ctx  = ctx_i;
  assign mid_d.prod = ProdWidth'(alpha_i) * ProdWidth'(one_minus);

  logic                p_v_q;
  nau_mid_t            p_mid_q;
  logic [RemWidth-1:0] p_rem_q;
  logic [DenWidth-1:0] p_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_mid_q <= mid_d;
      p_rem_q <= dividend;
      p_den_q <= one_plus;
    end
  end

  // restoring division, one quotient bit per stage
  logic                d_v_q   [QWidth];
  nau_mid_t            d_mid_q [QWidth];
  logic [RemWidth-1:0] d_rem_q [QWidth];
  logic [DenWidth-1:0] d_den_q [QWidth];
  logic [QWidth-1:0]   d_quo_q [QWidth];

  for (genvar j = 0; j < QWidth; j++) begin : g_bit
    localparam int unsigned Bit = QWidth - 1 - j;

    logic                src_v;
    nau_mid_t            src_mid;
    logic [RemWidth-1:0] src_rem;
    logic [DenWidth-1:0] src_den;
    logic [QWidth-1:0]   src_quo;
    logic [RemWidth-1:0] step;
    logic                ge;

    if (j == 0) begin : g_head
      assign src_v   = p_v_q;
      assign src_mid = p_mid_q;
      assign src_rem = p_rem_q;
      assign src_den = p_den_q;
      assign src_quo = '0;
    end else begin : g_body
      assign src_v   = d_v_q[j-1];
      assign src_mid = d_mid_q[j-1];
      assign src_rem = d_rem_q[j-1];
      assign src_den = d_den_q[j-1];
      assign src_quo = d_quo_q[j-1];
    end

    assign step = RemWidth'(src_den) << Bit;
    assign ge   = src_rem >= step;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[j] <= 1'b0;
      end else if (en_i) begin
        d_v_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_mid_q[j] <= src_mid;
        d_den_q[j] <= src_den;
        d_rem_q[j] <= ge ? (src_rem - step) : src_rem;
        d_quo_q[j] <= src_quo | (QWidth'(ge) << Bit);
      end
    end
  end

  assign valid_o = d_v_q[QWidth-1];
  assign mid_o   = d_mid_q[QWidth-1];
  assign quo_o   = d_quo_q[QWidth-1];

endmodule

>>> rtl/nau_post.sv
module nau_post
  import nau_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  nau_mid_t             mid_i,
  input  logic [FracBits:0]    quo_i,
  input  logic [CoefWidth-1:0] lambda_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output nau_out_t             out_data_o,
  output logic                 en_o
);

  localparam int unsigned MagWidth   = DataWidth + 5;
  localparam int unsigned ScaleWidth = DataWidth + CoefWidth;
  localparam logic [ProdWidth:0] EluRound = (ProdWidth + 1)'(1) << (43 - FracBits);
  localparam logic [MagWidth-1:0] LimNeg = MagWidth'(1) << (DataWidth - 1);
  localparam logic [MagWidth-1:0] LimPos = LimNeg - MagWidth'(1);

  logic en;
  logic out_load;

  // stage 1: pick the magnitude for the operation
  logic [ProdWidth:0]   elu_sum;
  logic [DataWidth-1:0] elu_mag;
  logic [DataWidth-1:0] rmag;
  logic                 rneg;

  assign elu_sum = {1'b0, mid_i.prod} + EluRound;
  assign elu_mag = DataWidth'(elu_sum >> (44 - FracBits));

  always_comb begin
    unique case (mid_i.ctx.op)
      OpIdent: begin
        rmag = mid_i.ctx.mag;
        rneg = mid_i.ctx.neg;
      end
      OpSigmoid: begin
        rmag = DataWidth'(quo_i);
        rneg = 1'b0;
      end
      OpTanh: begin
        rmag = DataWidth'(quo_i);
        rneg = mid_i.ctx.neg;
      end
      OpElu, OpSelu: begin
        rmag = mid_i.ctx.neg ? elu_mag : mid_i.ctx.mag;
        rneg = mid_i.ctx.neg;
      end
      OpRelu: begin
        rmag = mid_i.ctx.neg ? '0 : mid_i.ctx.mag;
        rneg = 1'b0;
      end
      default: begin
        rmag = '0;
        rneg = 1'b0;
      end
    endcase
  end

  logic                 s1_v_q;
  logic [DataWidth-1:0] s1_mag_q;
  logic                 s1_neg_q;
  logic                 s1_bad_q;
  logic                 s1_selu_q;

  // stage 2: lambda scaling, rounded half up on the magnitude
  logic [ScaleWidth-1:0] sprod;
  logic [ScaleWidth:0]   sround;
  logic [MagWidth-1:0]   mag2_d;

  assign sprod  = ScaleWidth'(s1_mag_q) * ScaleWidth'(lambda_i);
  assign sround = {1'b0, sprod} + (ScaleWidth + 1)'(2048);
  assign mag2_d = s1_selu_q ? sround[ScaleWidth:12] : MagWidth'(s1_mag_q);

  logic                s2_v_q;
  logic [MagWidth-1:0] s2_mag_q;
  logic                s2_neg_q;
  logic                s2_bad_q;

  // output register: clip and apply sign
  logic [MagWidth-1:0]  limit;
  logic                 sat;
  logic [MagWidth-1:0]  clip_mag;
  nau_out_t             out_d;
  logic                 out_valid_q;
  nau_out_t             out_data_q;

  assign limit    = s2_neg_q ? LimNeg : LimPos;
  assign sat      = s2_mag_q > limit;
  assign clip_mag = sat ? limit : s2_mag_q;

  always_comb begin
    if (s2_bad_q) begin
      out_d.y_value       = '0;
      out_d.bad_operation = 1'b1;
      out_d.saturated     = 1'b0;
    end else begin
      out_d.y_value       = s2_neg_q ? (DataWidth'(0) - clip_mag[DataWidth-1:0])
                                     : clip_mag[DataWidth-1:0];
      out_d.bad_operation = 1'b0;
      out_d.saturated     = sat;
    end
  end

  // the pipe keeps moving while the stage in front of the output is empty
  assign out_load = !out_valid_q || out_ready_i;
  assign en       = out_load || !s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        s1_v_q <= valid_i;
        s2_v_q <= s1_v_q;
      end
      if (out_load) begin
        out_valid_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q  <= rmag;
      s1_neg_q  <= rneg;
      s1_bad_q  <= mid_i.ctx.bad;
      s1_selu_q <= mid_i.ctx.op == OpSelu;
      s2_mag_q  <= mag2_d;
      s2_neg_q  <= s1_neg_q;
      s2_bad_q  <= s1_bad_q;
    end
    if (out_load && s2_v_q) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign en_o        = en;

endmodule

>>> rtl/nau_checker.sv
`include "neural_activation_unit_top_defines.svh"

module nau_checker
  import nau_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input nau_out_t out_data_o
);

  // an unknown code gives a plain zero
  `NAU_ASSERT_NOW(a_bad_gives_zero, out_valid_o && out_data_o.bad_operation, out_data_o.y_value == '0 && !out_data_o.saturated, "bad operation must give zero, unsaturated")

  // clipping lands exactly on a bound
  `NAU_ASSERT_NOW(a_sat_at_bound, out_valid_o && out_data_o.saturated, out_data_o.y_value == 32'sh7FFF_FFFF || out_data_o.y_value == 32'sh8000_0000, "saturated result is not a range bound")

  // an empty output register never blocks the input
  `NAU_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

  `NAU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind neural_activation_unit_top nau_checker u_nau_checker (.*);

>>> tb/tb.sv
module tb;
  import nau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac = 16;
  localparam logic [OpWidth-1:0] OpBadLo = 3'd6;
  localparam logic [OpWidth-1:0] OpBadHi = 3'd7;
  localparam logic [CfgIdxWidth-1:0] RegUnusedLo = 4'd2;
  localparam logic [63:0] OneQ = 64'h1_0000_0000;
  localparam logic [63:0] Ln2Q = 64'hB172_17F8;
  localparam int DrainCycles = 80;
  localparam int CycleLimit = 400000;
  localparam int NumRandom = 1630;

  typedef struct {
    nau_in_t  item;
    logic     typed;
    nau_out_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  nau_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  nau_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CoefWidth-1:0] cfg_data_i = '0;

  logic [15:0] alpha_q12 = EluAlphaRst;
  logic [15:0] lambda_q12 = SeluLambdaRst;
  nau_out_t expected_y[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  int stall_left = 0;
  bit out_taken = 0;
  bit no_stall = 0;
  bit no_gap = 0;
  int op_hits[8];
  int sat_hits = 0;

  neural_activation_unit_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // e^-m in Q32, m with Frac fractional bits
  function automatic logic [63:0] decay_q32(logic [63:0] m);
    logic [63:0] a, k, r, term, sum;
    if (m >= (64'd64 << Frac)) return 64'd0;
    a = m << (32 - Frac);
    k = a / Ln2Q;
    r = a - k * Ln2Q;
    term = OneQ;
    sum = OneQ;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * r) >> 32) / n;
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > OneQ) sum = OneQ;
    if (k >= 64) return 64'd0;
    return sum >> k;
  endfunction

  function automatic logic [63:0] ratio_frac(logic [63:0] num, logic [63:0] den);
    return ((num << Frac) + (den >> 1)) / den;
  endfunction

  function automatic logic [63:0] scale_q12(logic [63:0] mag, logic [63:0] coef);
    logic [63:0] p_hi, p_lo;
    p_hi = (mag >> 32) * coef;
    p_lo = (mag & 64'hFFFF_FFFF) * coef;
    if (p_hi >= (64'd1 << 43)) return '1;
    return (p_hi << 20) + ((p_lo + 64'd2048) >> 12);
  endfunction

  function automatic nau_out_t activate(nau_in_t it);
    nau_out_t res;
    logic [63:0] xs, mag, rmag, e, m2, limit;
    logic neg, rneg;
    xs = {{32{it.x_value[31]}}, it.x_value};
    neg = xs[63];
    mag = neg ? 64'd0 - xs : xs;
    rneg = 1'b0;
    rmag = 64'd0;
    res = '0;
    if (it.operation == OpBadLo || it.operation == OpBadHi) begin
      res.bad_operation = 1'b1;
      return res;
    end
    case (it.operation)
      OpIdent: begin
        rneg = neg;
        rmag = mag;
      end
      OpSigmoid: begin
        e = decay_q32(mag);
        rmag = ratio_frac(neg ? e : OneQ, OneQ + e);
      end
      OpTanh: begin
        m2 = ((mag < (64'd64 << Frac)) ? mag : (64'd64 << Frac)) * 2;
        e = decay_q32(m2);
        rneg = neg;
        rmag = ratio_frac(OneQ - e, OneQ + e);
      end
      OpElu, OpSelu: begin
        rneg = neg;
        if (neg) begin
          e = decay_q32(mag);
          rmag = (alpha_q12 * (OneQ - e) + (64'd1 << (43 - Frac))) >> (44 - Frac);
        end else begin
          rmag = mag;
        end
        if (it.operation == OpSelu) rmag = scale_q12(rmag, lambda_q12);
      end
      default: rmag = neg ? 64'd0 : mag;
    endcase
    limit = rneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (rmag > limit) begin
      rmag = limit;
      res.saturated = 1'b1;
    end
    res.y_value = rneg ? 32'(64'd0 - rmag) : 32'(rmag);
    return res;
  endfunction

  function automatic logic [31:0] draw_x();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 20 << Frac);
      2: v = (64 << Frac) + $urandom_range(0, 1024) - 512;
      3: v = $urandom_range(0, 255);
      4: v = 32'h7FFF_FFFF - $urandom_range(0, 65535);
      default: v = $urandom_range(0, 4 << Frac);
    endcase
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  function automatic int draw_wait();
    if ($urandom_range(0, 1)) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic send_item(nau_in_t it, logic typed, nau_out_t want);
    int gap;
    gap = no_gap ? 0 : draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_y.push_back(typed ? want : activate(it));
    op_hits[it.operation]++;
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegEluAlpha) alpha_q12 = val;
    else if (idx == RegSeluLambda) lambda_q12 = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_y.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken <= 1'b1;
      results_seen++;
      if (out_data_o.saturated) sat_hits++;
      if (expected_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", out_data_o);
      end else begin
        nau_out_t want;
        want = expected_y.pop_front();
        if (out_data_o.y_value !== want.y_value ||
            out_data_o.bad_operation !== want.bad_operation ||
            out_data_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y=%h bad=%b sat=%b, got y=%h bad=%b sat=%b",
                     want.y_value, want.bad_operation, want.saturated,
                     out_data_o.y_value, out_data_o.bad_operation, out_data_o.saturated);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken <= 1'b0;
      stall_left = no_stall ? 0 : draw_wait();
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d transactions pending", cycles,
               expected_y.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    nau_in_t it;
    logic [15:0] alphas[4];
    logic [15:0] lambdas[4];

    // directed rows: typed expectations only for trivial cases
    r.typed = 1'b1;
    r.item = '{OpIdent, 32'h7FFF_FFFF};    r.want = '{32'h7FFF_FFFF, 1'b0, 1'b0};
    rows.push_back(r);
    r.item = '{OpIdent, 32'h8000_0000};    r.want = '{32'h8000_0000, 1'b0, 1'b0};
    rows.push_back(r);
    r.item = '{OpRelu, 32'h8000_0000};     r.want = '{32'h0, 1'b0, 1'b0};
    rows.push_back(r);
    r.item = '{OpRelu, 32'h7FFF_FFFF};     r.want = '{32'h7FFF_FFFF, 1'b0, 1'b0};
    rows.push_back(r);
    r.item = '{OpBadLo, 32'h1234_5678};    r.want = '{32'h0, 1'b1, 1'b0};
    rows.push_back(r);
    r.item = '{OpBadHi, 32'hFFFF_FFFF};    r.want = '{32'h0, 1'b1, 1'b0};
    rows.push_back(r);
    r.item = '{OpElu, 32'h0};              r.want = '{32'h0, 1'b0, 1'b0};
    rows.push_back(r);
    r.item = '{OpSelu, 32'h0};             r.want = '{32'h0, 1'b0, 1'b0};
    rows.push_back(r);
    r.typed = 1'b0;
    r.want = '0;
    foreach (rows[i]) ;
    begin
      logic [31:0] xs[8];
      xs = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
             32'hFFFF_0000, 32'h0040_0000, 32'hFFC0_0000, 32'h0000_0001};
      for (int i = 0; i < 4; i++) begin
        r.item = '{OpSigmoid, xs[i * 2]};      rows.push_back(r);
        r.item = '{OpTanh, xs[i * 2 + 1]};     rows.push_back(r);
      end
      r.item = '{OpSelu, 32'h7FFF_FFFF};       rows.push_back(r);
      r.item = '{OpSelu, 32'h8000_0000};       rows.push_back(r);
      r.item = '{OpElu, 32'h8000_0000};        rows.push_back(r);
      r.item = '{OpElu, 32'hFFFF_8000};        rows.push_back(r);
      r.item = '{OpTanh, 32'h0};               rows.push_back(r);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    no_gap = 0;
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    alphas = '{16'd0, 16'hFFFF, 16'd0, EluAlphaRst};
    lambdas = '{16'd0, 16'hFFFF, 16'd0, SeluLambdaRst};
    alphas[2] = 16'($urandom());
    lambdas[2] = 16'($urandom());
    for (int p = 0; p < 4; p++) begin
      write_reg(RegEluAlpha, alphas[p]);
      write_reg(RegSeluLambda, lambdas[p]);
      // unknown index must leave both coefficients alone
      write_reg(4'($urandom_range(RegUnusedLo, 15)), 16'($urandom()));
      no_gap = (p == 1);
      no_stall = (p == 2);
      for (int n = 0; n < NumRandom / 4; n++) begin
        it.operation = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
        it.x_value = draw_x();
        send_item(it, 1'b0, '0);
      end
      drain();
      no_stall = 0;
    end

    $display("covered %0d results over 5 coefficient settings, %0d saturated",
             results_seen, sat_hits);
    $display("per operation: %p", op_hits);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/nau_pkg.sv
rtl/nau_front.sv
rtl/nau_exp.sv
rtl/nau_div.sv
rtl/nau_post.sv
rtl/neural_activation_unit_top.sv
rtl/nau_checker.sv
tb/tb.sv
